[rtl/frc_pkg.sv]
// frc_pkg: shared constants and types for the frame change refresh scheduler
// used by frc_store and frame_change_refresh_scheduler; no dependencies
`timescale 1ns / 1ps

package frc_pkg;

  // default frame size in bytes
  localparam int FRAME_BYTES_DEF = 1024;

  // item field widths
  localparam int BYTE_W  = 8;
  localparam int INDEX_W = 10;
  localparam int TIME_W  = 32;
  localparam int COUNT_W = 16;
  localparam int KIND_W  = 2;

  // stream data widths, padded to whole bytes
  localparam int IN_TDATA_W  = 56;
  localparam int OUT_TDATA_W = 8;

  // configuration port
  localparam int CFG_INDEX_W = 1;
  localparam int CFG_DATA_W  = 32;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_MAX_PARTIALS     = 1'b0,
    REG_FULL_INTERVAL_MS = 1'b1
  } cfg_reg_t;

  localparam logic [COUNT_W-1:0] MAX_PARTIALS_RST     = 16'd30;
  localparam logic [TIME_W-1:0]  FULL_INTERVAL_MS_RST = 32'd600000;
  localparam logic [COUNT_W-1:0] COUNT_TOP            = 16'hFFFF;

  // refresh decision codes
  typedef enum logic [KIND_W-1:0] {
    KIND_SKIP    = 2'd0,
    KIND_PARTIAL = 2'd1,
    KIND_FULL    = 2'd2
  } refresh_kind_t;

endpackage

[rtl/frc_store.sv]
// frc_store: last-sent frame memory with clearing pass after reset and
// write-to-read forwarding; depends on frc_pkg
`timescale 1ns / 1ps

module frc_store #(
  parameter int FRAME_BYTES = frc_pkg::FRAME_BYTES_DEF,
  parameter int AW          = $clog2(FRAME_BYTES)
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      rd_en,
  input  logic [AW-1:0]             rd_addr,
  output logic [frc_pkg::BYTE_W-1:0] rd_data,
  input  logic                      wr_en,
  input  logic [AW-1:0]             wr_addr,
  input  logic [frc_pkg::BYTE_W-1:0] wr_data,
  output logic                      busy
);
  import frc_pkg::*;

  logic [BYTE_W-1:0] mem [FRAME_BYTES];
  logic [BYTE_W-1:0] mem_q;
  logic [BYTE_W-1:0] fwd_data;
  logic              fwd;
  logic              clr_active;
  logic [AW-1:0]     clr_addr;
  logic              mem_we;
  logic [AW-1:0]     mem_waddr;
  logic [BYTE_W-1:0] mem_wdata;

  // clearing pass owns the write port until every entry is zero
  always_comb begin
    mem_we    = clr_active | wr_en;
    mem_waddr = clr_active ? clr_addr : wr_addr;
    mem_wdata = clr_active ? '0 : wr_data;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_active <= 1'b1;
      clr_addr   <= '0;
    end else if (clr_active) begin
      if (clr_addr == AW'(FRAME_BYTES - 1)) begin
        clr_active <= 1'b0;
      end
      clr_addr <= clr_addr + 1'b1;
    end
  end

  // memory array, read-first
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (rd_en) begin
      mem_q <= mem[rd_addr];
    end
  end

  // catch a write to the entry being read in the same cycle
  always_ff @(posedge clk) begin
    if (rd_en) begin
      fwd      <= wr_en && (wr_addr == rd_addr);
      fwd_data <= wr_data;
    end
  end

  assign rd_data = fwd ? fwd_data : mem_q;
  assign busy    = clr_active;

endmodule

[rtl/frame_change_refresh_scheduler.sv]
// frame_change_refresh_scheduler: compares frame bytes with the last-sent
// frame and decides skip, partial or full refresh; depends on frc_pkg, frc_store
`timescale 1ns / 1ps
//
// channel  | dir | handshake             | payload
// ---------+-----+-----------------------+----------------------------------
// s_axis   | in  | s_axis_tvalid/tready  | tdata: frame_byte, byte_index,
//          |     |                       | now_ms; tlast: last_byte
// m_axis   | out | m_axis_tvalid/tready  | tdata: refresh_kind
// cfg      | in  | cfg_valid/cfg_ready   | cfg_index, cfg_data
//
// One item per cycle unless stalled: a byte reads the memory when taken, waits
// in the compare stage registers, then is compared and written back. The
// decision on the last byte lands in an output register, so bytes keep flowing
// while a result waits. After reset a clearing pass writes zeros over the
// memory with s_axis_tready low; configuration writes are taken throughout.
// Otherwise input stalls only when a last byte waits on a full output register.

module frame_change_refresh_scheduler #(
  parameter int FRAME_BYTES = frc_pkg::FRAME_BYTES_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  // frame_byte [7:0], byte_index [17:8], now_ms [49:18], zeros above
  input  logic [frc_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
  input  logic                           s_axis_tlast,
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  // refresh_kind [1:0], zeros above
  output logic [frc_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [frc_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [frc_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import frc_pkg::*;

  localparam int AW = $clog2(FRAME_BYTES);

  logic [BYTE_W-1:0]  frame_byte;
  logic [INDEX_W-1:0] byte_index;
  logic [TIME_W-1:0]  now_ms;
  logic               in_fire;
  logic               in_range;

  // configuration registers
  logic [COUNT_W-1:0] max_partials;
  logic [TIME_W-1:0]  full_interval_ms;

  // compare stage
  logic               s1_valid;
  logic               s1_last;
  logic               s1_in_range;
  logic [AW-1:0]      s1_addr;
  logic [BYTE_W-1:0]  s1_byte;
  logic [TIME_W-1:0]  s1_now;
  logic               s1_fire;
  logic [BYTE_W-1:0]  old_byte;
  logic               store_busy;

  // decision state
  logic               frame_differs;
  logic [COUNT_W-1:0] partial_count;
  logic [TIME_W-1:0]  last_full_time;
  logic               differs_now;
  logic               go_full;
  logic [TIME_W-1:0]  elapsed;
  refresh_kind_t      kind_next;

  // output register
  logic               out_valid;
  refresh_kind_t      out_kind;
  logic               out_free;

  // unpack the input item
  assign frame_byte = s_axis_tdata[7:0];
  assign byte_index = s_axis_tdata[17:8];
  assign now_ms     = s_axis_tdata[49:18];
  assign in_range   = ({22'd0, byte_index} < 32'(FRAME_BYTES));

  // handshake
  assign out_free      = !out_valid || m_axis_tready;
  assign s1_fire       = s1_valid && (!s1_last || out_free);
  assign s_axis_tready = !store_busy && (!s1_valid || s1_fire);
  assign in_fire       = s_axis_tvalid && s_axis_tready;
  assign cfg_ready     = 1'b1;

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      max_partials     <= MAX_PARTIALS_RST;
      full_interval_ms <= FULL_INTERVAL_MS_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_MAX_PARTIALS:     max_partials     <= cfg_data[COUNT_W-1:0];
        REG_FULL_INTERVAL_MS: full_interval_ms <= cfg_data[TIME_W-1:0];
        default: ;
      endcase
    end
  end

  frc_store #(
    .FRAME_BYTES (FRAME_BYTES),
    .AW          (AW)
  ) u_store (
    .clk     (clk),
    .rst     (rst),
    .rd_en   (in_fire),
    .rd_addr (AW'(byte_index)),
    .rd_data (old_byte),
    .wr_en   (s1_fire && s1_in_range),
    .wr_addr (s1_addr),
    .wr_data (s1_byte),
    .busy    (store_busy)
  );

  // compare stage registers
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_fire) begin
      s1_valid <= 1'b1;
    end else if (s1_fire) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_last     <= s_axis_tlast;
      s1_in_range <= in_range;
      s1_addr     <= AW'(byte_index);
      s1_byte     <= frame_byte;
      s1_now      <= now_ms;
    end
  end

  // decision on the last byte
  always_comb begin
    differs_now = frame_differs || (s1_in_range && (old_byte != s1_byte));
    elapsed     = s1_now - last_full_time;
    go_full     = (partial_count >= max_partials) || (elapsed >= full_interval_ms);
    if (!differs_now) begin
      kind_next = KIND_SKIP;
    end else if (go_full) begin
      kind_next = KIND_FULL;
    end else begin
      kind_next = KIND_PARTIAL;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_differs  <= 1'b0;
      partial_count  <= '0;
      last_full_time <= '0;
    end else if (s1_fire) begin
      if (s1_last) begin
        frame_differs <= 1'b0;
        case (kind_next)
          KIND_FULL: begin
            partial_count  <= '0;
            last_full_time <= s1_now;
          end
          KIND_PARTIAL: begin
            if (partial_count != COUNT_TOP) begin
              partial_count <= partial_count + 1'b1;
            end
          end
          default: ;
        endcase
      end else begin
        frame_differs <= differs_now;
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_fire && s1_last) begin
      out_valid <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire && s1_last) begin
      out_kind <= kind_next;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {{(OUT_TDATA_W - KIND_W){1'b0}}, out_kind};

endmodule

[sim/frame_change_refresh_scheduler_tb.sv]
// frame_change_refresh_scheduler_tb: self-checking bench that streams frames of bytes,
// tracks the refresh decisions in a local model and checks every output item
// depends on frc_pkg and frame_change_refresh_scheduler
`timescale 1ns / 1ps

module frame_change_refresh_scheduler_tb;
  import frc_pkg::*;

  localparam int FRAME_LEN = FRAME_BYTES_DEF;

  logic                   clk;
  logic                   rst;
  // frame_byte [7:0], byte_index [17:8], now_ms [49:18], zeros above
  logic [IN_TDATA_W-1:0]  s_axis_tdata;
  logic                   s_axis_tlast;
  logic                   s_axis_tvalid;
  logic                   s_axis_tready;
  // refresh_kind [1:0], zeros above
  logic [OUT_TDATA_W-1:0] m_axis_tdata;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready;
  logic                   cfg_valid;
  logic                   cfg_ready;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0]  cfg_data;

  // local copy of the scheduler state
  logic [BYTE_W-1:0]  sent_copy [FRAME_LEN];
  logic               frame_changed;
  logic [COUNT_W-1:0] partial_cnt;
  logic [TIME_W-1:0]  full_stamp;
  logic [COUNT_W-1:0] lim_partials;
  logic [TIME_W-1:0]  lim_interval;

  refresh_kind_t kind_q [$];

  int          mismatches;
  int          bytes_sent;
  int          decisions_seen;
  int          kind_seen [3];
  bit          quiet;
  logic [31:0] clock_ms;

  frame_change_refresh_scheduler dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  // clock
  initial clk = 1'b0;
  always #10 clk = ~clk;

  // watchdog
  initial begin
    #10_000_000;
    $display("FAILURE");
    $finish;
  end

  function automatic int draw_gap();
    if (quiet) return 0;
    return $urandom_range(0, 13);
  endfunction

  // model one accepted byte; a last byte queues the decision it causes
  task automatic track_byte(input logic [7:0] b, input logic [9:0] idx, input logic last,
                            input logic [31:0] t);
    logic [31:0] elapsed;
    if (idx < FRAME_LEN) begin
      if (sent_copy[idx] != b) frame_changed = 1'b1;
      sent_copy[idx] = b;
    end
    if (last) begin
      if (!frame_changed) begin
        kind_q.push_back(KIND_SKIP);
      end else begin
        elapsed = t - full_stamp;
        if (partial_cnt >= lim_partials || elapsed >= lim_interval) begin
          partial_cnt = '0;
          full_stamp  = t;
          kind_q.push_back(KIND_FULL);
        end else begin
          if (partial_cnt != COUNT_TOP) partial_cnt = partial_cnt + 1'b1;
          kind_q.push_back(KIND_PARTIAL);
        end
      end
      frame_changed = 1'b0;
    end
  endtask

  // send one item; called and returning at a falling edge
  task automatic send_byte(input logic [7:0] b, input logic [9:0] idx, input logic last,
                           input logic [31:0] t);
    int gap;
    gap = draw_gap();
    if (gap > 0) begin
      s_axis_tvalid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_axis_tdata  = {6'd0, t, idx, b};
    s_axis_tlast  = last;
    s_axis_tvalid = 1'b1;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    track_byte(b, idx, last, t);
    bytes_sent++;
    @(negedge clk);
  endtask

  // let all pending decisions come out, with the input held idle
  task automatic wait_idle();
    s_axis_tvalid = 1'b0;
    while (kind_q.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_reg(input cfg_reg_t r, input logic [31:0] v);
    cfg_index = r;
    cfg_data  = v;
    cfg_valid = 1'b1;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    if (r == REG_MAX_PARTIALS) lim_partials = v[COUNT_W-1:0];
    else lim_interval = v;
    @(negedge clk);
  endtask

  // both registers, written only with the block idle
  task automatic set_limits(input logic [15:0] maxp, input logic [31:0] interval);
    logic [15:0] junk;
    wait_idle();
    junk = 16'($urandom_range(0, 65535));
    write_reg(REG_MAX_PARTIALS, {junk, maxp});
    write_reg(REG_FULL_INTERVAL_MS, interval);
    cfg_valid = 1'b0;
  endtask

  task automatic note_mismatch(input string what, input logic [7:0] want,
                               input logic [7:0] got);
    mismatches++;
    if (mismatches <= 10)
      $display("mismatch (%s) at %0t ns: expected %0d, got %0d", what, $time, want, got);
  endtask

  // result checker
  always @(posedge clk) begin
    refresh_kind_t want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      decisions_seen++;
      if (m_axis_tdata[KIND_W-1:0] < 3) kind_seen[m_axis_tdata[KIND_W-1:0]]++;
      if (kind_q.size() == 0) begin
        note_mismatch("no decision pending", 8'hxx, m_axis_tdata);
      end else begin
        want = kind_q.pop_front();
        if (m_axis_tdata !== {{(OUT_TDATA_W-KIND_W){1'b0}}, want})
          note_mismatch("refresh_kind", {{(OUT_TDATA_W-KIND_W){1'b0}}, want}, m_axis_tdata);
      end
    end
  end

  // receiver with random stalls per item
  initial begin
    int stall;
    m_axis_tready = 1'b0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      stall = draw_gap();
      if (stall > 0) begin
        m_axis_tready = 1'b0;
        repeat (stall) @(negedge clk);
      end
      m_axis_tready = 1'b1;
      @(posedge clk);
      while (!m_axis_tvalid) @(posedge clk);
      @(negedge clk);
    end
  end

  // reset values, missing bytes, interval boundary and time wrap
  task automatic test_reset_decisions();
    send_byte(8'h00, 10'd0, 1'b1, 32'd0);
    send_byte(8'hFF, 10'd1023, 1'b0, 32'hFFFF_FFFF);
    send_byte(8'h00, 10'd0, 1'b1, 32'd100);
    // unsent bytes keep their stored value
    send_byte(8'hFF, 10'd1023, 1'b1, 32'd200);
    send_byte(8'hA5, 10'd1023, 1'b1, full_stamp + lim_interval - 1);
    send_byte(8'h5A, 10'd512, 1'b1, full_stamp + lim_interval);
    // elapsed time across the 32-bit wrap
    send_byte(8'h11, 10'd5, 1'b1, 32'hFFFF_FF00);
    send_byte(8'h22, 10'd5, 1'b1, 32'h0000_0010);
    send_byte(8'h33, 10'd5, 1'b1, full_stamp + lim_interval);
  endtask

  // zero limits force a full refresh on every changed frame
  task automatic test_zero_limits();
    set_limits(16'd0, 32'd600000);
    send_byte(~sent_copy[6], 10'd6, 1'b1, full_stamp + 1);
    send_byte(sent_copy[6], 10'd6, 1'b1, full_stamp + 2);
    set_limits(16'd30, 32'd0);
    send_byte(~sent_copy[7], 10'd7, 1'b1, full_stamp);
    send_byte(~sent_copy[7], 10'd7, 1'b1, full_stamp + 3);
  endtask

  // largest limits, largest elapsed time, and a count limit of one
  task automatic test_limit_extremes();
    set_limits(16'hFFFF, 32'hFFFF_FFFF);
    send_byte(~sent_copy[8], 10'd8, 1'b1, full_stamp + 5);
    send_byte(~sent_copy[8], 10'd8, 1'b1, full_stamp - 1);
    set_limits(16'd1, 32'hFFFF_FFFF);
    send_byte(~sent_copy[9], 10'd9, 1'b1, full_stamp + 7);
    send_byte(~sent_copy[9], 10'd9, 1'b1, full_stamp + 8);
    send_byte(~sent_copy[9], 10'd9, 1'b1, full_stamp + 9);
  endtask

  // random frames of 1 to 40 bytes under one register setting
  task automatic test_random_frames(input logic [15:0] maxp, input logic [31:0] interval,
                                    input int n_items);
    int          stop_at;
    int          len;
    int          hot;
    bit          same_all;
    logic [9:0]  idx;
    logic [7:0]  b;
    logic [31:0] step_max;
    set_limits(maxp, interval);
    clock_ms = full_stamp;
    stop_at  = bytes_sent + n_items;
    step_max = (lim_interval >> 2) == 0 ? 32'd1000 : (lim_interval >> 2);
    while (bytes_sent < stop_at) begin
      if ($urandom_range(0, 15) == 0) quiet = !quiet;
      len      = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 12);
      same_all = ($urandom_range(0, 5) == 0);
      hot      = $urandom_range(0, 1023 - 63);
      for (int i = 0; i < len; i++) begin
        if ($urandom_range(0, 1)) idx = 10'(hot + $urandom_range(0, 63));
        else idx = 10'($urandom_range(0, 1023));
        if (same_all || $urandom_range(0, 2) == 0) b = sent_copy[idx];
        else b = 8'($urandom_range(0, 255));
        if (i != len - 1) begin
          send_byte(b, idx, 1'b0, $urandom);
        end else begin
          case ($urandom_range(0, 7))
            0: clock_ms = $urandom;
            1: clock_ms = full_stamp + lim_interval;
            2: clock_ms = full_stamp + lim_interval - 1;
            default: clock_ms = clock_ms + $urandom_range(0, step_max);
          endcase
          send_byte(b, idx, 1'b1, clock_ms);
        end
      end
    end
    quiet = 1'b0;
  endtask

  initial begin
    rst           = 1'b1;
    s_axis_tdata  = '0;
    s_axis_tlast  = 1'b0;
    s_axis_tvalid = 1'b0;
    cfg_valid     = 1'b0;
    cfg_index     = REG_MAX_PARTIALS;
    cfg_data      = '0;
    mismatches    = 0;
    bytes_sent    = 0;
    decisions_seen = 0;
    kind_seen     = '{0, 0, 0};
    quiet         = 1'b0;
    clock_ms      = '0;
    foreach (sent_copy[i]) sent_copy[i] = '0;
    frame_changed = 1'b0;
    partial_cnt   = '0;
    full_stamp    = '0;
    lim_partials  = MAX_PARTIALS_RST;
    lim_interval  = FULL_INTERVAL_MS_RST;

    repeat (5) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_reset_decisions();
    test_zero_limits();
    test_limit_extremes();
    test_random_frames(16'd30, 32'd600000, 300);
    test_random_frames(16'd3, 32'd20000, 300);
    test_random_frames(16'd0, 32'hFFFF_FFFF, 300);
    test_random_frames(16'hFFFF, 32'hFFFF_FFFF, 300);
    test_random_frames(16'($urandom_range(0, 8)), $urandom_range(1, 100000), 300);
    test_random_frames(16'($urandom_range(0, 65535)), 32'd0, 300);

    wait_idle();
    repeat (8) @(negedge clk);
    $display("run covered %0d frame bytes and %0d decisions: %0d skip, %0d partial, %0d full",
             bytes_sent, decisions_seen, kind_seen[0], kind_seen[1], kind_seen[2]);
    $display("register settings from zero to all ones; %0d mismatches", mismatches);
    if (mismatches == 0 && kind_q.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
